// ===== rtl/sequence_reorder_buffer_defines.svh =====
// ----------------------------------------------------------------------------
// Sequence reorder buffer: assertion macros
// Shared concurrent assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_REORDER_BUFFER_DEFINES_SVH
`define SEQUENCE_REORDER_BUFFER_DEFINES_SVH

// condition holds in the same cycle
`define SRB_ASSERT_NOW(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error(msg);

// condition holds in the following cycle
`define SRB_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error(msg);

// condition holds a fixed number of cycles later
`define SRB_ASSERT_AFTER(label, clk, rst_n, a, n, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) \
		else $error(msg);

`endif

// ===== rtl/srb_pkg.sv =====
// ----------------------------------------------------------------------------
// Sequence reorder buffer package
// Request/result payloads, command and register codes shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package srb_pkg;

	localparam logic [23:0] BYTE_LIMIT_RESET = 24'd30720;

	typedef enum logic [2:0] {
		DISP_DELIVERED = 3'd0,
		DISP_STORED    = 3'd1,
		DISP_DUPLICATE = 3'd2,
		DISP_REJECTED  = 3'd3,
		DISP_RELEASED  = 3'd4
	} disp_t;

	typedef enum logic [0:0] {
		CFG_BYTE_LIMIT     = 1'b0,
		CFG_FIRST_SEQUENCE = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		CMD_DUPLICATE = 2'd0,
		CMD_REJECT    = 2'd1,
		CMD_STORE     = 2'd2,
		CMD_DELIVER   = 2'd3
	} cmd_kind_t;

	typedef enum logic [0:0] {
		B_IDLE  = 1'b0,
		B_DRAIN = 1'b1
	} back_state_t;

	typedef struct packed {
		logic [31:0] seq_num;
		logic [15:0] byte_len;
		logic [15:0] packet_tag;
	} request_t;

	typedef struct packed {
		disp_t       disposition;
		logic [31:0] out_seq;
		logic [15:0] out_tag;
		logic        last;
	} result_t;

	// classified request handed from front to back
	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] seq_num;
		logic [15:0] byte_len;
		logic [15:0] packet_tag;
	} cmd_t;

	// back-end state seen by the classifier
	typedef struct packed {
		logic [31:0] expected_seq;
		logic [23:0] held_bytes;
		logic [23:0] byte_limit;
	} view_t;

	typedef struct packed {
		logic        we;
		cfg_index_t  index;
		logic [31:0] data;
	} cfg_write_t;

endpackage

`default_nettype wire

// ===== rtl/srb_front.sv =====
// ----------------------------------------------------------------------------
// Sequence reorder buffer: front end
// Two-stage classifier: serial distance and slot index, then the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_front #(
	parameter int WINDOW_SLOTS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              accept,
	input  wire srb_pkg::request_t                 request,
	input  wire srb_pkg::view_t                    view,
	input  wire logic [$clog2(WINDOW_SLOTS)-1:0]   slot_base,
	input  wire logic [WINDOW_SLOTS-1:0]           slot_valid,
	input  wire logic                              q_full,
	output logic                                   push,
	output srb_pkg::cmd_t                          cmd,
	output logic [$clog2(WINDOW_SLOTS)-1:0]        cmd_idx,
	output logic                                   busy
);

	localparam int IW = $clog2(WINDOW_SLOTS);
	localparam logic [IW:0] WIN_SUM = (IW+1)'(WINDOW_SLOTS);

	logic                valid_s1, valid_s2;
	srb_pkg::request_t   req_s1, req_s2;
	logic                old_s2, zero_s2, win_s2;
	logic [IW:0]         sum_s2;

	logic [31:0] gap;
	logic [IW:0] sum;
	logic        stall;
	logic [IW-1:0] idx;
	logic        held_dup;
	logic        over_limit;

	assign stall = valid_s2 & q_full;
	assign busy  = valid_s1 | valid_s2;
	assign push  = valid_s2 & ~q_full;

	// stage 1: serial distance from the expected number
	assign gap = req_s1.seq_num - view.expected_seq;
	assign sum = {1'b0, slot_base} + {1'b0, gap[IW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= request;
		end
		if (!stall) begin
			req_s2  <= req_s1;
			old_s2  <= gap[31];
			zero_s2 <= (gap == 32'd0);
			win_s2  <= (gap < 32'(WINDOW_SLOTS));
			sum_s2  <= sum;
		end
	end

	// stage 2: fold slot index, check occupancy and byte budget
	assign idx = (sum_s2 >= WIN_SUM) ? IW'(sum_s2 - WIN_SUM) : sum_s2[IW-1:0];
	assign held_dup   = ~zero_s2 & win_s2 & slot_valid[idx];
	assign over_limit = ({1'b0, view.held_bytes} + 25'(req_s2.byte_len))
		> {1'b0, view.byte_limit};

	always_comb begin
		cmd.seq_num    = req_s2.seq_num;
		cmd.byte_len   = req_s2.byte_len;
		cmd.packet_tag = req_s2.packet_tag;
		cmd_idx        = idx;
		priority if (old_s2 || held_dup) begin
			cmd.kind = srb_pkg::CMD_DUPLICATE;
		end else if (over_limit || !win_s2) begin
			cmd.kind = srb_pkg::CMD_REJECT;
		end else if (!zero_s2) begin
			cmd.kind = srb_pkg::CMD_STORE;
		end else begin
			cmd.kind = srb_pkg::CMD_DELIVER;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/srb_queue.sv =====
// ----------------------------------------------------------------------------
// Sequence reorder buffer: command queue
// Two-entry FIFO decoupling the classifier from the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_queue #(
	parameter int IDX_W = 5
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire srb_pkg::cmd_t        push_cmd,
	input  wire logic [IDX_W-1:0]     push_idx,
	input  wire logic                 pop,
	output srb_pkg::cmd_t             head_cmd,
	output logic [IDX_W-1:0]          head_idx,
	output logic                      empty,
	output logic                      full
);

	srb_pkg::cmd_t      cmd_q [2];
	logic [IDX_W-1:0]   idx_q [2];
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         count_q;

	logic do_push, do_pop;

	assign empty    = (count_q == 2'd0);
	assign full     = (count_q == 2'd2);
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;
	assign head_cmd = cmd_q[rd_ptr_q];
	assign head_idx = idx_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			cmd_q[wr_ptr_q] <= push_cmd;
			idx_q[wr_ptr_q] <= push_idx;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/srb_back.sv =====
// ----------------------------------------------------------------------------
// Sequence reorder buffer: back end
// Executes classified commands, owns the slot store and drains held packets.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_back #(
	parameter int WINDOW_SLOTS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire srb_pkg::cfg_write_t               cfg,
	input  wire srb_pkg::cmd_t                     head_cmd,
	input  wire logic [$clog2(WINDOW_SLOTS)-1:0]   head_idx,
	input  wire logic                              q_empty,
	output logic                                   pop,
	output srb_pkg::view_t                         view,
	output logic [$clog2(WINDOW_SLOTS)-1:0]        slot_base,
	output logic [WINDOW_SLOTS-1:0]                slot_valid,
	output logic                                   busy,
	output logic                                   result_valid,
	output srb_pkg::result_t                       result
);

	localparam int IW = $clog2(WINDOW_SLOTS);

	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] len;
	} slot_entry_t;

	srb_pkg::back_state_t state_q, state_d;
	logic [31:0]          expected_q, exp_d;
	logic [23:0]          held_q, held_d;
	logic [23:0]          limit_q;
	logic [IW-1:0]        base_q, base_d, next_base;
	logic [WINDOW_SLOTS-1:0] valid_q, valid_d;
	logic                 result_valid_q, res_vld_d;
	srb_pkg::result_t     result_q, res_d;

	slot_entry_t          slot_mem [WINDOW_SLOTS];
	slot_entry_t          rd_q;
	logic                 mem_we;

	assign next_base    = (base_q == IW'(WINDOW_SLOTS - 1)) ? '0 : base_q + 1'b1;
	assign view         = '{expected_seq: expected_q, held_bytes: held_q, byte_limit: limit_q};
	assign slot_base    = base_q;
	assign slot_valid   = valid_q;
	assign busy         = (state_q != srb_pkg::B_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srb_pkg::B_IDLE: begin
				if (!q_empty && head_cmd.kind == srb_pkg::CMD_DELIVER
						&& valid_q[next_base]) begin
					state_d = srb_pkg::B_DRAIN;
				end
			end
			srb_pkg::B_DRAIN: begin
				if (!valid_q[next_base]) begin
					state_d = srb_pkg::B_IDLE;
				end
			end
			default: state_d = srb_pkg::B_IDLE;
		endcase
	end

	// datapath and results
	always_comb begin
		pop               = 1'b0;
		mem_we            = 1'b0;
		res_vld_d         = 1'b0;
		res_d.disposition = srb_pkg::DISP_DUPLICATE;
		res_d.out_seq     = head_cmd.seq_num;
		res_d.out_tag     = head_cmd.packet_tag;
		res_d.last        = 1'b1;
		exp_d             = expected_q;
		held_d            = held_q;
		base_d            = base_q;
		valid_d           = valid_q;
		unique case (state_q)
			srb_pkg::B_IDLE: begin
				if (!q_empty) begin
					pop       = 1'b1;
					res_vld_d = 1'b1;
					unique case (head_cmd.kind)
						srb_pkg::CMD_DUPLICATE: res_d.disposition = srb_pkg::DISP_DUPLICATE;
						srb_pkg::CMD_REJECT:    res_d.disposition = srb_pkg::DISP_REJECTED;
						srb_pkg::CMD_STORE: begin
							res_d.disposition = srb_pkg::DISP_STORED;
							mem_we            = 1'b1;
							valid_d[head_idx] = 1'b1;
							held_d            = held_q + 24'(head_cmd.byte_len);
						end
						srb_pkg::CMD_DELIVER: begin
							res_d.disposition = srb_pkg::DISP_DELIVERED;
							res_d.last        = ~valid_q[next_base];
							exp_d             = expected_q + 32'd1;
							base_d            = next_base;
						end
						default: res_d.disposition = srb_pkg::DISP_DUPLICATE;
					endcase
				end
			end
			srb_pkg::B_DRAIN: begin
				// rd_q holds the entry at base_q, read ahead last cycle
				res_vld_d         = 1'b1;
				res_d.disposition = srb_pkg::DISP_RELEASED;
				res_d.out_seq     = expected_q;
				res_d.out_tag     = rd_q.tag;
				res_d.last        = ~valid_q[next_base];
				held_d            = held_q - 24'(rd_q.len);
				valid_d[base_q]   = 1'b0;
				exp_d             = expected_q + 32'd1;
				base_d            = next_base;
			end
			default: res_vld_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= srb_pkg::B_IDLE;
			expected_q     <= 32'd0;
			held_q         <= 24'd0;
			limit_q        <= srb_pkg::BYTE_LIMIT_RESET;
			base_q         <= '0;
			valid_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= res_vld_d;
			// a first_sequence write restarts the sequence and empties the store
			if (cfg.we && cfg.index == srb_pkg::CFG_FIRST_SEQUENCE) begin
				expected_q <= cfg.data;
				held_q     <= 24'd0;
				base_q     <= '0;
				valid_q    <= '0;
			end else begin
				expected_q <= exp_d;
				held_q     <= held_d;
				base_q     <= base_d;
				valid_q    <= valid_d;
			end
			if (cfg.we && cfg.index == srb_pkg::CFG_BYTE_LIMIT) begin
				limit_q <= cfg.data[23:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	// slot store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[head_idx] <= '{tag: head_cmd.packet_tag, len: head_cmd.byte_len};
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= slot_mem[next_base];
	end

endmodule

`default_nettype wire

// ===== rtl/sequence_reorder_buffer.sv =====
// ----------------------------------------------------------------------------
// Sequence reorder buffer
// Puts arriving packets back in sequence order, holding early ones in slots.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive request and raise start; the request is taken at
//   an edge where start is high and busy is low. One request at a time.
//   Result channel: each result appears for exactly one cycle with
//   result_valid high; result.last marks the final result of a request.
//   The receiver cannot stall, so results are never held back.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high. Write only while busy is low and no result is pending.
//   Writing first_sequence empties the store and restarts the sequence.
// Pipeline:
//   The first result follows the accepting edge through the input register,
//   two classifier stages, the command queue and the executor result
//   register. A request that releases k held packets gives k more results,
//   one per cycle, set by the one-entry-per-cycle read port of the slot
//   store. The next request is taken once busy drops with the final result.
// Reset: empty store, held bytes zero, expected sequence zero, byte limit
//   30720. No clearing pass; slot valid bits reset in flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sequence_reorder_buffer_defines.svh"

module sequence_reorder_buffer #(
	parameter int WINDOW_SLOTS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// request channel
	input  wire logic                start,
	output logic                     busy,
	input  wire srb_pkg::request_t   request,
	// result channel
	output logic                     result_valid,
	output srb_pkg::result_t         result,
	// config channel
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire srb_pkg::cfg_index_t cfg_index,
	input  wire logic [31:0]         cfg_data
);

	localparam int IW = $clog2(WINDOW_SLOTS);

	logic                 accept;
	logic                 front_busy, back_busy;
	logic                 q_push, q_pop, q_empty, q_full;
	srb_pkg::cmd_t        push_cmd, head_cmd;
	logic [IW-1:0]        push_idx, head_idx;
	srb_pkg::view_t       view;
	logic [IW-1:0]        slot_base;
	logic [WINDOW_SLOTS-1:0] slot_valid;
	srb_pkg::cfg_write_t  cfg;

	// one request in flight: busy covers classifier, queue and drain
	assign busy      = front_busy | ~q_empty | back_busy;
	assign accept    = start & ~busy;
	assign cfg_ready = 1'b1;
	assign cfg       = '{we: cfg_valid, index: cfg_index, data: cfg_data};

	// front: register the request, classify against current state
	srb_front #(
		.WINDOW_SLOTS(WINDOW_SLOTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.request    (request),
		.view       (view),
		.slot_base  (slot_base),
		.slot_valid (slot_valid),
		.q_full     (q_full),
		.push       (q_push),
		.cmd        (push_cmd),
		.cmd_idx    (push_idx),
		.busy       (front_busy)
	);

	// short command queue between the two halves
	srb_queue #(
		.IDX_W(IW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.push_idx (push_idx),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.head_idx (head_idx),
		.empty    (q_empty),
		.full     (q_full)
	);

	// back: execute, store, drain consecutive held packets
	srb_back #(
		.WINDOW_SLOTS(WINDOW_SLOTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.head_cmd     (head_cmd),
		.head_idx     (head_idx),
		.q_empty      (q_empty),
		.pop          (q_pop),
		.view         (view),
		.slot_base    (slot_base),
		.slot_valid   (slot_valid),
		.busy         (back_busy),
		.result_valid (result_valid),
		.result       (result)
	);

	// queue never sees a push while full
	`SRB_ASSERT_NOW(a_queue_no_overflow, clk, arst_n, q_push, !q_full, "command queue overflow")
	// first result of each request comes a fixed time after acceptance
	`SRB_ASSERT_AFTER(a_first_result_latency, clk, arst_n, accept, 4, result_valid, "first result late")
	// a non-final result is always followed by a release in the next cycle
	`SRB_ASSERT_NEXT(a_drain_continues, clk, arst_n, result_valid && !result.last, result_valid && result.disposition == srb_pkg::DISP_RELEASED, "drain burst broken")
	// the final result leaves the block ready for the next request
	`SRB_ASSERT_NOW(a_idle_after_last, clk, arst_n, result_valid && result.last, !busy, "busy after final result")

endmodule

`default_nettype wire

// ===== tb/sv/srb_order_checker.sv =====
// ----------------------------------------------------------------------------
// Sequence reorder buffer checker
// Watches the request, config and result channels, predicts every result from
// its own copy of the reorder state and compares them in arrival order.
// ----------------------------------------------------------------------------
module srb_order_checker #(
	parameter int WINDOW_SLOTS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  srb_pkg::request_t   request,
	input  logic                result_valid,
	input  srb_pkg::result_t    result,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  srb_pkg::cfg_index_t cfg_index,
	input  logic [31:0]         cfg_data,
	output int                  failures,
	output int                  results_due
);
	import srb_pkg::*;

	logic [23:0] byte_limit;
	logic [31:0] next_seq;
	logic [23:0] held_bytes;
	int          base_slot;
	logic        slot_full [WINDOW_SLOTS];
	logic [15:0] slot_tag  [WINDOW_SLOTS];
	logic [15:0] slot_len  [WINDOW_SLOTS];
	result_t     due_results [$];

	function automatic result_t make_result(disp_t disp, logic [31:0] seq,
			logic [15:0] tag, logic fin);
		result_t r;
		r.disposition = disp;
		r.out_seq     = seq;
		r.out_tag     = tag;
		r.last        = fin;
		return r;
	endfunction

	function automatic void empty_store();
		int i;
		for (i = 0; i < WINDOW_SLOTS; i++) begin
			slot_full[i] = 1'b0;
		end
		held_bytes = '0;
		base_slot  = 0;
	endfunction

	function automatic void apply_register(cfg_index_t idx, logic [31:0] value);
		case (idx)
			CFG_BYTE_LIMIT: begin
				byte_limit = value[23:0];
			end
			CFG_FIRST_SEQUENCE: begin
				next_seq = value;
				empty_store();
			end
		endcase
	endfunction

	// expected results of one packet request
	function automatic void reorder_packet(request_t pkt);
		logic [31:0] ahead;
		logic [24:0] demand;
		logic        near;
		int          slot;
		int          drained;
		result_t     r;
		ahead  = pkt.seq_num - next_seq;
		demand = held_bytes + pkt.byte_len;
		near   = ahead < WINDOW_SLOTS;
		slot   = near ? (base_slot + int'(ahead)) % WINDOW_SLOTS : 0;
		if (ahead[31] || (near && ahead != 0 && slot_full[slot])) begin
			// behind the window, or the slot already holds this number
			due_results.push_back(make_result(DISP_DUPLICATE, pkt.seq_num,
				pkt.packet_tag, 1'b1));
		end else if (demand > byte_limit || !near) begin
			due_results.push_back(make_result(DISP_REJECTED, pkt.seq_num,
				pkt.packet_tag, 1'b1));
		end else if (ahead != 0) begin
			slot_full[slot] = 1'b1;
			slot_tag[slot]  = pkt.packet_tag;
			slot_len[slot]  = pkt.byte_len;
			held_bytes      = held_bytes + pkt.byte_len;
			due_results.push_back(make_result(DISP_STORED, pkt.seq_num,
				pkt.packet_tag, 1'b1));
		end else begin
			// in order: deliver, then release the consecutive held run
			r         = make_result(DISP_DELIVERED, pkt.seq_num, pkt.packet_tag, 1'b0);
			next_seq  = next_seq + 1;
			base_slot = (base_slot + 1) % WINDOW_SLOTS;
			drained   = 0;
			while (drained < WINDOW_SLOTS && slot_full[base_slot]) begin
				due_results.push_back(r);
				r = make_result(DISP_RELEASED, next_seq, slot_tag[base_slot], 1'b0);
				held_bytes           = held_bytes - slot_len[base_slot];
				slot_full[base_slot] = 1'b0;
				next_seq             = next_seq + 1;
				base_slot            = (base_slot + 1) % WINDOW_SLOTS;
				drained++;
			end
			r.last = 1'b1;
			due_results.push_back(r);
		end
	endfunction

	function automatic void compare_result(result_t got);
		result_t want;
		if (due_results.size() == 0) begin
			$display("%0t: result with none expected: disp=%0d seq=%h tag=%h last=%b",
				$time, got.disposition, got.out_seq, got.out_tag, got.last);
			failures++;
		end else begin
			want = due_results.pop_front();
			if (got.disposition !== want.disposition || got.out_seq !== want.out_seq ||
					got.out_tag !== want.out_tag || got.last !== want.last) begin
				$display("%0t: expected disp=%0d seq=%h tag=%h last=%b, got disp=%0d seq=%h tag=%h last=%b",
					$time, want.disposition, want.out_seq, want.out_tag, want.last,
					got.disposition, got.out_seq, got.out_tag, got.last);
				failures++;
			end
		end
	endfunction

	// results are checked before a new request is predicted on the same edge
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_limit = BYTE_LIMIT_RESET;
			next_seq   = '0;
			failures   = 0;
			empty_store();
			due_results.delete();
		end else begin
			if (result_valid) begin
				compare_result(result);
			end
			if (cfg_valid && cfg_ready) begin
				apply_register(cfg_index, cfg_data);
			end
			if (start && !busy) begin
				reorder_packet(request);
			end
		end
		results_due = due_results.size();
	end

endmodule

// ===== tb/sv/sequence_reorder_buffer_test.sv =====
// ----------------------------------------------------------------------------
// Sequence reorder buffer testbench
// Drives packet requests and register writes into the reorder buffer; a
// checker beside it predicts every delivery, store, release and rejection.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_test;
	import srb_pkg::*;

	localparam int WINDOW_SLOTS  = 32;
	localparam int SETTLE_CYCLES = 8;     // pipeline latency plus margin
	localparam int QUIET_LIMIT   = 1000;  // cycles with no handshake at all

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	request_t    request   = '0;
	logic        cfg_valid = 1'b0;
	cfg_index_t  cfg_index = CFG_BYTE_LIMIT;
	logic [31:0] cfg_data  = '0;
	logic        busy;
	logic        result_valid;
	logic        cfg_ready;
	result_t     result;
	int          failures;
	int          results_due;

	// stimulus bookkeeping
	int          sent_count   = 0;
	int          idle_pct     = 0;      // chance in percent of a gap before a request
	int          cur_limit    = 30720;  // byte limit the block is running with
	int          quiet_cycles = 0;
	logic [31:0] head         = '0;     // first sequence number of the next burst

	sequence_reorder_buffer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	srb_order_checker #(
		.WINDOW_SLOTS (WINDOW_SLOTS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.failures     (failures),
		.results_due  (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog: any request, result or register write restarts the count
	always @(posedge clk) begin
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("sequence_reorder_buffer verification failed");
			$finish;
		end else if (!arst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One request. Called at a rising edge; returns at the edge that took it,
	// with start still high so a following request can go back to back.
	task automatic send_packet(input logic [31:0] seq, input logic [15:0] len,
			input logic [15:0] tag);
		request_t r;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		r.seq_num    = seq;
		r.byte_len   = len;
		r.packet_tag = tag;
		request <= r;
		start   <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent_count++;
	endtask

	// Drop start and wait for the block to go quiet: no result outstanding,
	// not busy, then the latency again in case anything is still in flight.
	task automatic settle();
		start <= 1'b0;
		@(negedge clk);
		while (results_due != 0 || busy) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_index_t idx, input logic [31:0] value);
		settle();
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Off-stream traffic: anywhere at all, stale, or WINDOW_SLOTS-2 to WINDOW_SLOTS+40 past head.
	task automatic noise_packet(input int span);
		case ($urandom_range(2))
			0: send_packet($urandom, 16'($urandom), 16'($urandom));
			1: send_packet(head - $urandom_range(1, 40), 16'($urandom), 16'($urandom));
			default: send_packet(head + $urandom_range(WINDOW_SLOTS - 2, WINDOW_SLOTS + 40),
				16'($urandom_range(span)), 16'($urandom));
		endcase
	endtask

	// Bursts: each covers head .. head+k-1 in a random order, so stores pile
	// up until the in-order packet arrives and drains them. Long bursts are
	// sometimes sent in reverse to fill up to the whole window before one drain.
	// Lengths stay at a 64th of the limit so a full window never overflows it.
	task automatic run_bursts(input int item_goal);
		logic [31:0] order [$];
		logic [31:0] tmp;
		int          k;
		int          j;
		int          pick;
		int          span;
		bit          descending;
		span = (cur_limit / 64 > 65535) ? 65535 : cur_limit / 64;
		while (sent_count < item_goal) begin
			k = ($urandom_range(4) == 0) ? $urandom_range(20, WINDOW_SLOTS) : $urandom_range(1, 8);
			descending = (k >= 20) && ($urandom_range(2) == 0);
			order.delete();
			for (j = 0; j < k; j++) begin
				order.push_back(descending ? head + k - 1 - j : head + j);
			end
			if (!descending) begin
				for (j = k - 1; j > 0; j--) begin
					pick        = $urandom_range(j);
					tmp         = order[j];
					order[j]    = order[pick];
					order[pick] = tmp;
				end
			end
			for (j = 0; j < k; j++) begin
				send_packet(order[j], 16'($urandom_range(span)), 16'($urandom));
				// retransmission of something already sent in this burst
				if ($urandom_range(7) == 0) begin
					send_packet(order[$urandom_range(j)], 16'($urandom_range(span)),
						16'($urandom));
				end
				if ($urandom_range(9) == 0) begin
					noise_packet(span);
				end
			end
			head = head + k;
		end
	endtask

	initial begin
		int j;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- phase one: reset settings, sender pauses now and then ----
		idle_pct = 20;
		send_packet(32'd2, 16'd100, 16'hFFFF);           // stored
		send_packet(32'd2, 16'd7, 16'h1234);             // already held
		send_packet(32'd1, 16'hFFFF, 16'h0000);          // over the byte limit
		send_packet(32'd32, 16'd0, 16'h0001);            // one past the window
		send_packet(32'd31, 16'd0, 16'h0002);            // last slot of the window
		send_packet(32'hFFFF_FFFF, 16'd1, 16'h0003);     // just behind: duplicate
		send_packet(32'h8000_0000, 16'd1, 16'h0004);     // half-range distance counts as behind
		send_packet(32'h7FFF_FFFF, 16'd1, 16'h0005);     // far ahead: rejected
		send_packet(32'd0, 16'd30621, 16'h0006);         // in order but one byte over
		send_packet(32'd0, 16'd30620, 16'h0007);         // in order, exactly at the limit
		send_packet(32'd0, 16'd1, 16'h0008);             // already delivered
		send_packet(32'd1, 16'd5, 16'hAAAA);             // delivers and releases seq 2
		send_packet(32'd5, 16'd10, 16'h5555);
		send_packet(32'd4, 16'd10, 16'h0F0F);
		send_packet(32'd6, 16'd10, 16'hF0F0);
		send_packet(32'd3, 16'd0, 16'h0009);             // releases 4, 5, 6
		send_packet(32'd8, 16'd1, 16'h0010);
		send_packet(32'd10, 16'd1, 16'h0011);
		send_packet(32'd9, 16'd1, 16'h0012);
		send_packet(32'd7, 16'd2, 16'h0013);             // releases 8, 9, 10
		send_packet(32'd12, 16'd30720, 16'h0014);        // fills the byte limit exactly
		send_packet(32'd13, 16'd1, 16'h0015);            // no room left
		send_packet(32'd11, 16'd0, 16'h0016);            // releases 12
		head = 32'd13;
		run_bursts(90);

		// ---- phase two: widest limit, sequence wraps through zero ----
		idle_pct = 61;
		write_register(CFG_BYTE_LIMIT, 32'h00FF_FFFF);
		cur_limit = 24'hFF_FFFF;
		write_register(CFG_FIRST_SEQUENCE, 32'hFFFF_FFF0);
		head = 32'hFFFF_FFF0;
		run_bursts(150);
		// leave a few packets held across the next limit change
		for (j = 1; j <= 5; j++) begin
			send_packet(head + j, 16'($urandom_range(1, 100)), 16'($urandom));
		end

		// ---- phase three: back to back, limit dropped below held bytes ----
		idle_pct = 0;
		write_register(CFG_BYTE_LIMIT, 32'd0);
		cur_limit = 0;
		send_packet(head, 16'd0, 16'($urandom));         // held bytes alone exceed it
		send_packet(head + 3, 16'd0, 16'($urandom));     // still held
		send_packet(head + 7, 16'd0, 16'($urandom));
		write_register(CFG_BYTE_LIMIT, 32'd1000);
		cur_limit = 1000;
		send_packet(head, 16'd0, 16'($urandom));         // drains the held five
		head = head + 6;
		run_bursts(180);
		write_register(CFG_FIRST_SEQUENCE, 32'h7FFF_FFF0);
		head = 32'h7FFF_FFF0;
		run_bursts(195);
		write_register(CFG_BYTE_LIMIT, 32'(BYTE_LIMIT_RESET));
		cur_limit = int'(BYTE_LIMIT_RESET);
		write_register(CFG_FIRST_SEQUENCE, 32'd0);
		head = 32'd0;
		run_bursts(210);

		settle();
		$display("%0d packet requests in three pacing phases, window-wide drains included;",
			sent_count);
		$display("byte limit 0 to max, first sequence 0, 0x7ffffff0 and 0xfffffff0");
		if (failures == 0) begin
			$display("sequence_reorder_buffer verification clean");
		end else begin
			$display("sequence_reorder_buffer verification failed");
		end
		$finish;
	end

endmodule
